### hw/rtl/mqsi_pkg.sv
// Shared types and constants for the multi-queue store with sorted insert.
// Used by mqsi_engine and multi_queue_with_sorted_insert; no dependencies.
`default_nettype none

package mqsi_pkg;

    localparam int NUM_QUEUES_DEF  = 7;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam int ID_W  = 8;
    localparam int KEY_W = 32;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_INSERT = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        t_opcode op;
        t_entry  entry;
    } t_item;

    typedef struct packed {
        logic    valid;
        logic    cnt_we;
        t_status status;
        t_entry  entry;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/mqsi_engine.sv
// Entry memory and scan/shift sequencer for the multi-queue store.
// Depends on mqsi_pkg.
`default_nettype none

module mqsi_engine #(
    parameter int NUM_QUEUES  = mqsi_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqsi_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire mqsi_pkg::t_item                        i_item,
    input  wire logic                                   i_q_ok,
    input  wire logic [(NUM_QUEUES > 1 ? $clog2(NUM_QUEUES) : 1)-1:0] i_q_idx,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]       i_cnt,
    input  wire logic                                   i_taken,
    output logic                                        o_busy,
    output mqsi_pkg::t_result                           o_result,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]            o_cnt
);

    localparam int CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int PW       = $clog2(QUEUE_DEPTH);
    localparam int MEM_D    = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW       = $clog2(MEM_D);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FINAL = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_issue, n_issue;
    logic   r_rd_vld, n_rd_vld;

    mqsi_pkg::t_opcode r_op, n_op;
    mqsi_pkg::t_status r_status, n_status;
    mqsi_pkg::t_entry  r_item, n_item;
    mqsi_pkg::t_entry  r_carry, n_carry;
    mqsi_pkg::t_entry  r_out, n_out;
    mqsi_pkg::t_entry  r_rd_data;
    mqsi_pkg::t_entry  r_mem [MEM_D];

    logic          r_found, n_found;
    logic          r_cnt_we, n_cnt_we;
    logic [AW-1:0] r_base, n_base;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_new_cnt, n_new_cnt;
    logic [PW-1:0] r_rd_idx, n_rd_idx;
    logic [PW-1:0] r_rd_pos, n_rd_pos;
    logic [PW-1:0] r_last, n_last;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    mqsi_pkg::t_entry wr_data;
    logic             hit;
    logic             full;

    assign rd_en   = (r_state == S_SCAN) && r_issue;
    assign rd_addr = r_base + AW'(r_rd_idx);
    assign full    = (i_cnt == CW'(QUEUE_DEPTH));
    // pop takes the head, remove takes the first id match
    assign hit     = (r_op == mqsi_pkg::OP_POP) ? (r_rd_pos == '0)
                                                : (r_rd_data.id == r_item.id);

    always_comb begin
        n_state   = r_state;
        n_issue   = r_issue;
        n_rd_vld  = r_rd_vld;
        n_op      = r_op;
        n_status  = r_status;
        n_item    = r_item;
        n_carry   = r_carry;
        n_out     = r_out;
        n_found   = r_found;
        n_cnt_we  = r_cnt_we;
        n_base    = r_base;
        n_cnt     = r_cnt;
        n_new_cnt = r_new_cnt;
        n_rd_idx  = r_rd_idx;
        n_rd_pos  = r_rd_pos;
        n_last    = r_last;
        wr_en     = 1'b0;
        wr_addr   = r_base + AW'(r_rd_pos);
        wr_data   = r_carry;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op      = i_item.op;
                    n_status  = mqsi_pkg::ST_OK;
                    n_item    = i_item.entry;
                    n_carry   = i_item.entry;
                    n_out     = '0;
                    n_found   = 1'b0;
                    n_cnt_we  = 1'b0;
                    n_base    = AW'(32'(i_q_idx) * 32'(QUEUE_DEPTH));
                    n_cnt     = i_cnt;
                    n_new_cnt = i_cnt;
                    n_rd_idx  = '0;
                    n_rd_vld  = 1'b0;
                    n_last    = PW'(i_cnt - 1'b1);
                    n_issue   = 1'b0;
                    n_state   = S_RESP;
                    if (i_q_ok) begin
                        case (i_item.op)
                            mqsi_pkg::OP_APPEND: begin
                                if (full) n_status = mqsi_pkg::ST_FULL;
                                else n_state = S_FINAL;
                            end
                            mqsi_pkg::OP_INSERT: begin
                                if (full) begin
                                    n_status = mqsi_pkg::ST_FULL;
                                end else if (i_cnt == '0) begin
                                    n_state = S_FINAL;
                                end else begin
                                    n_state = S_SCAN;
                                    n_issue = 1'b1;
                                end
                            end
                            mqsi_pkg::OP_POP, mqsi_pkg::OP_PEEK: begin
                                if (i_cnt == '0) begin
                                    n_status = mqsi_pkg::ST_EMPTY;
                                end else begin
                                    n_state = S_SCAN;
                                    n_issue = 1'b1;
                                    if (i_item.op == mqsi_pkg::OP_PEEK) n_last = '0;
                                end
                            end
                            mqsi_pkg::OP_REMOVE: begin
                                if (i_cnt == '0) begin
                                    n_status = mqsi_pkg::ST_NOTFOUND;
                                end else begin
                                    n_state = S_SCAN;
                                    n_issue = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            S_SCAN: begin
                // reads run one entry ahead of the writes they feed
                if (r_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    if (r_rd_idx == r_last) n_issue = 1'b0;
                end
                n_rd_vld = r_issue;
                n_rd_pos = r_rd_idx;

                if (r_rd_vld) begin
                    case (r_op)
                        mqsi_pkg::OP_PEEK: n_out = r_rd_data;
                        mqsi_pkg::OP_POP, mqsi_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                wr_en   = 1'b1;
                                wr_addr = r_base + AW'(r_rd_pos - 1'b1);
                                wr_data = r_rd_data;
                            end else if (hit) begin
                                n_found = 1'b1;
                                if (r_op == mqsi_pkg::OP_POP) n_out = r_rd_data;
                            end
                        end
                        mqsi_pkg::OP_INSERT: begin
                            // from the insert point on, each entry moves up one slot
                            if (r_found || (r_rd_data.key > r_item.key)) begin
                                wr_en   = 1'b1;
                                wr_data = r_carry;
                                n_carry = r_rd_data;
                                n_found = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    if (r_rd_pos == r_last) begin
                        n_state = S_RESP;
                        case (r_op)
                            mqsi_pkg::OP_INSERT: n_state = S_FINAL;
                            mqsi_pkg::OP_POP: begin
                                n_cnt_we  = 1'b1;
                                n_new_cnt = r_cnt - 1'b1;
                            end
                            mqsi_pkg::OP_REMOVE: begin
                                if (r_found || hit) begin
                                    n_cnt_we  = 1'b1;
                                    n_new_cnt = r_cnt - 1'b1;
                                end else begin
                                    n_status = mqsi_pkg::ST_NOTFOUND;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            S_FINAL: begin
                wr_en     = 1'b1;
                wr_addr   = r_base + AW'(r_cnt);
                wr_data   = r_carry;
                n_cnt_we  = 1'b1;
                n_new_cnt = r_cnt + 1'b1;
                n_state   = S_RESP;
            end

            S_RESP: begin
                if (i_taken) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_status  <= n_status;
        r_item    <= n_item;
        r_carry   <= n_carry;
        r_out     <= n_out;
        r_found   <= n_found;
        r_cnt_we  <= n_cnt_we;
        r_base    <= n_base;
        r_cnt     <= n_cnt;
        r_new_cnt <= n_new_cnt;
        r_rd_idx  <= n_rd_idx;
        r_rd_pos  <= n_rd_pos;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[rd_addr];
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_result.valid  = (r_state == S_RESP);
    assign o_result.cnt_we = r_cnt_we;
    assign o_result.status = r_status;
    assign o_result.entry  = r_out;
    assign o_cnt           = r_new_cnt;

endmodule

`default_nettype wire

### hw/rtl/multi_queue_with_sorted_insert.sv
// Top level of the multi-queue store: beat handshakes, queue counts, result register.
// Depends on mqsi_pkg and mqsi_engine.
`default_nettype none

// NUM_QUEUES queues of up to QUEUE_DEPTH (id, key) entries share one entry memory
// with one read and one write port, walked one entry per cycle by a small sequencer.
// Operations that end at once (empty, full, bad queue or opcode) go straight to the result;
// append writes its entry in a final step; pop and remove on a queue holding N entries
// scan all N of them, sorted insert scans them and then writes, and peek reads the head.
// The input stalls while an operation is in progress and while its result waits for
// the output register; one finished result may wait in the output register while
// the next beat is taken. The entry memory needs no clearing after reset.
module multi_queue_with_sorted_insert #(
    parameter int NUM_QUEUES  = mqsi_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqsi_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mqsi_pkg::ID_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [2:0]  i_queue_sel,
    input  wire logic [7:0]  i_proc_id,
    input  wire logic [31:0] i_burst_key,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_out_id,
    output logic [31:0]      o_out_key
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [mqsi_pkg::ID_W-1:0] ID_MASK = (ID_BITS >= mqsi_pkg::ID_W) ?
        {mqsi_pkg::ID_W{1'b1}} : mqsi_pkg::ID_W'((1 << ID_BITS) - 1);

    logic [CW-1:0] r_counts [NUM_QUEUES];
    logic [QW-1:0] r_q_idx;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [7:0]    r_out_id;
    logic [31:0]   r_out_key;

    logic              accept;
    logic              busy;
    logic              q_ok;
    logic [QW-1:0]     q_idx;
    logic [CW-1:0]     cnt_in;
    logic [CW-1:0]     cnt_out;
    logic              slot_free;
    logic              taken;
    mqsi_pkg::t_item   item;
    mqsi_pkg::t_result result;

    assign q_ok      = (32'(i_queue_sel) < 32'(NUM_QUEUES));
    assign q_idx     = QW'(i_queue_sel);
    assign cnt_in    = q_ok ? r_counts[q_idx] : '0;
    assign accept    = i_in_valid && !busy;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign taken     = result.valid && slot_free;

    assign item.op        = mqsi_pkg::t_opcode'(i_opcode);
    assign item.entry.id  = i_proc_id & ID_MASK;
    assign item.entry.key = i_burst_key;

    mqsi_engine #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_item   (item),
        .i_q_ok   (q_ok),
        .i_q_idx  (q_idx),
        .i_cnt    (cnt_in),
        .i_taken  (taken),
        .o_busy   (busy),
        .o_result (result),
        .o_cnt    (cnt_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) r_counts[i] <= '0;
        end else begin
            if (taken) begin
                r_out_valid <= 1'b1;
                if (result.cnt_we) r_counts[r_q_idx] <= cnt_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_q_idx <= q_idx;
        if (taken) begin
            r_status  <= result.status;
            r_out_id  <= result.entry.id;
            r_out_key <= result.entry.key;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_key   = r_out_key;

endmodule

`default_nettype wire

### dv/multi_queue_with_sorted_insert_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_queue_with_sorted_insert: a scoreboard class keeps
// its own copy of the seven queues and predicts each result beat.
// Depends on mqsi_pkg and the RTL of the block.

module multi_queue_with_sorted_insert_tb;

    localparam int NQ = mqsi_pkg::NUM_QUEUES_DEF;
    localparam int QD = mqsi_pkg::QUEUE_DEPTH_DEF;
    localparam logic [7:0] ID_MASK = 8'((1 << mqsi_pkg::ID_BITS_DEF) - 1);
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [2:0] QSEL_NONE = 3'd7;
    localparam int RAND_ITEMS = 500;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum int { MIX_ALL, MIX_FILL, MIX_DRAIN } t_mix;

    typedef struct {
        mqsi_pkg::t_status status;
        logic [7:0]        id;
        logic [31:0]       key;
    } t_sched_result;

    class queue_scoreboard;
        mqsi_pkg::t_entry slots[NQ][$];
        t_sched_result    pending[$];
        int unsigned      errors;

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // Applies one accepted request to the shadow queues and queues its result.
        function void note_request(logic [2:0] op, logic [2:0] qsel, logic [7:0] id,
                                   logic [31:0] key);
            t_sched_result    res;
            mqsi_pkg::t_entry ent;
            int               pos;
            res.status = mqsi_pkg::ST_OK;
            res.id = '0;
            res.key = '0;
            ent.id = id & ID_MASK;
            ent.key = key;
            if (qsel < NQ) begin
                case (op)
                    mqsi_pkg::OP_APPEND, mqsi_pkg::OP_INSERT: begin
                        if (slots[qsel].size() >= QD) begin
                            res.status = mqsi_pkg::ST_FULL;
                        end else begin
                            pos = slots[qsel].size();
                            if (op == mqsi_pkg::OP_INSERT) begin
                                // stable: goes after every entry with an equal key
                                pos = 0;
                                while (pos < slots[qsel].size() && slots[qsel][pos].key <= key)
                                    pos++;
                            end
                            slots[qsel].insert(pos, ent);
                        end
                    end
                    mqsi_pkg::OP_POP, mqsi_pkg::OP_PEEK: begin
                        if (slots[qsel].size() == 0) begin
                            res.status = mqsi_pkg::ST_EMPTY;
                        end else begin
                            res.id = slots[qsel][0].id;
                            res.key = slots[qsel][0].key;
                            if (op == mqsi_pkg::OP_POP) void'(slots[qsel].pop_front());
                        end
                    end
                    mqsi_pkg::OP_REMOVE: begin
                        pos = 0;
                        while (pos < slots[qsel].size() && slots[qsel][pos].id != ent.id)
                            pos++;
                        if (pos == slots[qsel].size()) res.status = mqsi_pkg::ST_NOTFOUND;
                        else slots[qsel].delete(pos);
                    end
                    default: begin
                    end
                endcase
            end
            pending.push_back(res);
        endfunction

        task check_result(logic [1:0] st, logic [7:0] id, logic [31:0] key);
            t_sched_result want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, status %0d", st));
                return;
            end
            want = pending.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (id !== want.id)
                report_mismatch($sformatf("out_id %02h, want %02h", id, want.id));
            if (key !== want.key)
                report_mismatch($sformatf("out_key %08h, want %08h", key, want.key));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [2:0]  i_queue_sel;
    logic [7:0]  i_proc_id;
    logic [31:0] i_burst_key;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [7:0]  o_out_id;
    logic [31:0] o_out_key;

    queue_scoreboard sb = new();
    bit              no_idle;
    int unsigned     cycles;
    int unsigned     stall_run;
    bit              stall_on;

    multi_queue_with_sorted_insert #(
        .NUM_QUEUES  (mqsi_pkg::NUM_QUEUES_DEF),
        .QUEUE_DEPTH (mqsi_pkg::QUEUE_DEPTH_DEF),
        .ID_BITS     (mqsi_pkg::ID_BITS_DEF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_queue_sel (i_queue_sel),
        .i_proc_id   (i_proc_id),
        .i_burst_key (i_burst_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_key   (o_out_key)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_on = ($urandom_range(0, 2) == 0);
            stall_run = stall_on ? idle_len() + 1 : $urandom_range(1, 8);
        end
        stall_run--;
        i_out_stall <= stall_on && !no_idle;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_out_id, o_out_key);
    end

    task automatic send_beat(input logic [2:0] op, input logic [2:0] qsel,
                             input logic [7:0] id, input logic [31:0] key);
        int n;
        i_opcode <= op;
        i_queue_sel <= qsel;
        i_proc_id <= id;
        i_burst_key <= key;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, qsel, id, key);
        n = no_idle ? 0 : idle_len();
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    function automatic logic [2:0] pick_op(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (r < 40) return mqsi_pkg::OP_APPEND;
                if (r < 85) return mqsi_pkg::OP_INSERT;
                if (r < 90) return mqsi_pkg::OP_PEEK;
                if (r < 96) return mqsi_pkg::OP_REMOVE;
            end
            MIX_DRAIN: begin
                if (r < 10) return mqsi_pkg::OP_APPEND;
                if (r < 20) return mqsi_pkg::OP_INSERT;
                if (r < 55) return mqsi_pkg::OP_POP;
                if (r < 65) return mqsi_pkg::OP_PEEK;
                if (r < 96) return mqsi_pkg::OP_REMOVE;
            end
            default: begin
                if (r < 22) return mqsi_pkg::OP_APPEND;
                if (r < 44) return mqsi_pkg::OP_INSERT;
                if (r < 62) return mqsi_pkg::OP_POP;
                if (r < 72) return mqsi_pkg::OP_PEEK;
                if (r < 96) return mqsi_pkg::OP_REMOVE;
            end
        endcase
        return 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    // Returns 1 when the beat reaches a real queue with a real operation.
    task automatic random_beat(input t_mix mix, input logic [2:0] focus, output bit counted);
        logic [2:0]  op;
        logic [2:0]  qsel;
        logic [7:0]  id;
        logic [31:0] key;
        int          r;
        op = pick_op(mix);
        if ($urandom_range(0, 99) < 3) qsel = QSEL_NONE;
        else if (mix != MIX_ALL && $urandom_range(0, 4) != 0) qsel = focus;
        else qsel = 3'($urandom_range(0, NQ - 1));
        // a narrow id pool gives duplicates
        id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r < 4) key = 32'($urandom_range(0, 15));
        else if (r == 4) key = '0;
        else if (r == 5) key = '1;
        else key = $urandom;
        if (op == mqsi_pkg::OP_REMOVE && qsel < NQ && sb.slots[qsel].size() != 0
                && $urandom_range(0, 9) < 7)
            id = sb.slots[qsel][$urandom_range(0, sb.slots[qsel].size() - 1)].id;
        send_beat(op, qsel, id, key);
        counted = (qsel < NQ) && (op <= mqsi_pkg::OP_INSERT);
    endtask

    initial begin
        int   done;
        bit   counted;
        bit   drained_mid;
        t_mix mix;
        logic [2:0] focus;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode <= mqsi_pkg::OP_APPEND;
        i_queue_sel <= '0;
        i_proc_id <= '0;
        i_burst_key <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, extremes, equal keys, duplicate ids, ignored requests
        send_beat(mqsi_pkg::OP_PEEK, 3'd0, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd0, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_REMOVE, 3'd0, 8'd9, 32'd0);
        send_beat(mqsi_pkg::OP_INSERT, 3'd0, 8'hFF, 32'hFFFF_FFFF);
        send_beat(mqsi_pkg::OP_INSERT, 3'd0, 8'h00, 32'h0000_0000);
        send_beat(mqsi_pkg::OP_INSERT, 3'd0, 8'h01, 32'd5);
        send_beat(mqsi_pkg::OP_INSERT, 3'd0, 8'h02, 32'd5);
        send_beat(mqsi_pkg::OP_APPEND, 3'd0, 8'h01, 32'd7);
        send_beat(mqsi_pkg::OP_REMOVE, 3'd0, 8'h01, 32'd0);
        send_beat(mqsi_pkg::OP_PEEK, 3'd0, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd0, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd0, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_APPEND, 3'd6, 8'hAA, 32'h5555_AAAA);
        send_beat(mqsi_pkg::OP_INSERT, 3'd6, 8'h55, 32'hAAAA_5555);
        send_beat(mqsi_pkg::OP_PEEK, 3'd6, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_APPEND, QSEL_NONE, 8'hFF, 32'hFFFF_FFFF);
        send_beat(OP_UNUSED_LO, 3'd1, 8'h10, 32'd1);
        send_beat(OP_UNUSED_MID, 3'd2, 8'h20, 32'd2);
        send_beat(OP_UNUSED_HI, 3'd0, 8'h30, 32'd3);
        send_beat(mqsi_pkg::OP_REMOVE, 3'd6, 8'h77, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd6, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd6, 8'd0, 32'd0);
        send_beat(mqsi_pkg::OP_POP, 3'd6, 8'd0, 32'd0);
        wait_drained();

        done = 0;
        drained_mid = 1'b0;
        while (done < RAND_ITEMS) begin
            mix = t_mix'($urandom_range(0, 2));
            focus = 3'($urandom_range(0, NQ - 1));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (40) begin
                random_beat(mix, focus, counted);
                if (counted) done++;
            end
            if (!drained_mid && done >= RAND_ITEMS / 2) begin
                drained_mid = 1'b1;
                wait_drained();
            end
        end
        no_idle = 1'b0;
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
